// ===== rtl/core/vrw_pkg.sv =====
// Shared types and constants for the voxel ray walker.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package vrw_pkg;

    // Fraction bits of the unit direction components.
    localparam int DIR_BITS  = 30;
    // Step limit of one walk.
    localparam int MAX_STEPS = 63;
    // Width of a full voxel index, wide enough for any coordinate over a cell of one.
    localparam int COORD_W   = 34;
    // Width of a ray parameter value; the saturated maximum is bit 62.
    localparam int TIME_W    = 63;
    // Divider operand widths.
    localparam int NUM_W     = 62;
    localparam int DEN_W     = 33;

    localparam logic [TIME_W-1:0] T_INF = {1'b1, {(TIME_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [1:0] REG_CELL_X = 2'd0;
    localparam logic [1:0] REG_CELL_Y = 2'd1;
    localparam logic [1:0] REG_CELL_Z = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [TIME_W-1:0]         t_time;

    // One ray request.
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } t_ray;

    // One visited voxel.
    typedef struct packed {
        logic signed [15:0] voxel_x;
        logic signed [15:0] voxel_y;
        logic signed [15:0] voxel_z;
        logic [31:0]        segment_length;
        logic               is_last;
        logic               truncated;
    } t_res;

    // Walk set-up handed from the front end to the stepping engine.
    typedef struct packed {
        t_coord [2:0] cur;
        t_coord [2:0] last;
        logic   [2:0] neg;
        t_time  [2:0] tmax;
        t_time  [2:0] tdel;
    } t_setup;

endpackage

// ===== rtl/core/vrw_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vrw_pkg for the operand widths.
`timescale 1ns / 1ps

module vrw_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vrw_pkg::NUM_W-1:0]   i_num,
    input  logic [vrw_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [vrw_pkg::NUM_W-1:0]   o_quo,
    output logic [vrw_pkg::DEN_W-1:0]   o_rem
);

    localparam int CNT_W = $clog2(vrw_pkg::NUM_W + 1);

    logic [vrw_pkg::NUM_W-1:0] r_num;
    logic [vrw_pkg::DEN_W-1:0] r_rem;
    logic [vrw_pkg::DEN_W-1:0] r_den;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;
    logic [vrw_pkg::DEN_W:0]   trial;
    logic                      fits;

    // Shift in the next numerator bit and try to subtract the divisor.
    assign trial = {r_rem, r_num[vrw_pkg::NUM_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_cnt <= CNT_W'(vrw_pkg::NUM_W);
            end else if (r_cnt != '0) begin
                r_rem  <= fits ? vrw_pkg::DEN_W'(trial - {1'b0, r_den})
                               : trial[vrw_pkg::DEN_W-1:0];
                r_num  <= {r_num[vrw_pkg::NUM_W-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/vrw_front.sv =====
// Front end: takes a ray, holds the cell size registers and works out the walk set-up.
// Depends on vrw_pkg and the shared divider vrw_div.
`timescale 1ns / 1ps

module vrw_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  vrw_pkg::t_ray         i_ray,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [30:0]           i_cfg_data,
    output logic                  o_setup_push,
    input  logic                  i_setup_full,
    output vrw_pkg::t_setup       o_setup
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV_S, ST_DIV_E, ST_HALVE, ST_SQ, ST_SQRT,
        ST_DIV_A, ST_DIV_TM, ST_DIV_TD, ST_PUSH
    } t_state;

    t_state r_state;
    logic [1:0]  r_ax;
    logic        r_wait;
    logic [30:0] r_cell [3];
    logic [30:0] r_c    [3];
    logic signed [31:0] r_s [3];
    logic signed [31:0] r_e [3];
    logic [32:0] r_mag  [3];
    logic [30:0] r_r    [3];
    logic [61:0] r_prod;
    logic [63:0] r_sum;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [31:0] r_len;
    logic [30:0] r_a;
    vrw_pkg::t_setup r_setup;

    logic                      div_start;
    logic [vrw_pkg::NUM_W-1:0] div_num;
    logic [vrw_pkg::DEN_W-1:0] div_den;
    logic                      div_done;
    logic [vrw_pkg::NUM_W-1:0] div_quo;
    logic [vrw_pkg::DEN_W-1:0] div_rem;

    logic signed [31:0] sel_s, sel_e, sel_p;
    logic [31:0] abs_p;
    logic [30:0] span;
    logic [63:0] sq_try;
    logic [31:0] q32;
    logic [30:0] rem31;
    vrw_pkg::t_coord fl_q;
    logic [30:0] a_next;
    logic signed [32:0] diff [3];
    logic [32:0]        adiff [3];

    // Operands of the axis in progress.
    always_comb begin
        sel_s = r_s[0];
        sel_e = r_e[0];
        unique case (r_ax)
            2'd1:    begin sel_s = r_s[1]; sel_e = r_e[1]; end
            2'd2:    begin sel_s = r_s[2]; sel_e = r_e[2]; end
            default: begin sel_s = r_s[0]; sel_e = r_e[0]; end
        endcase
        sel_p = (r_state == ST_DIV_E) ? sel_e : sel_s;
        abs_p = sel_p[31] ? 32'(-sel_p) : 32'(sel_p);
        span  = r_setup.neg[r_ax] ? r_r[r_ax] : 31'(r_c[r_ax] - r_r[r_ax]);
    end

    // Floor quotient of a signed coordinate from the magnitude division.
    assign q32   = div_quo[31:0];
    assign rem31 = div_rem[30:0];
    always_comb begin
        if (!sel_p[31]) begin
            fl_q = vrw_pkg::COORD_W'(q32);
        end else if (rem31 == '0) begin
            fl_q = -vrw_pkg::t_coord'(q32);
        end else begin
            fl_q = -vrw_pkg::t_coord'(q32) - 1'b1;
        end
    end

    // Rounded direction magnitude, clipped at one.
    assign a_next = (div_quo > vrw_pkg::NUM_W'(1 << vrw_pkg::DIR_BITS))
                  ? 31'(1 << vrw_pkg::DIR_BITS) : div_quo[30:0];

    // Divider operand selection.
    always_comb begin
        div_num = vrw_pkg::NUM_W'(abs_p);
        div_den = vrw_pkg::DEN_W'(r_c[r_ax]);
        unique case (r_state)
            ST_DIV_A: begin
                div_num = vrw_pkg::NUM_W'({r_mag[r_ax][30:0], 30'b0})
                        + vrw_pkg::NUM_W'(r_len >> 1);
                div_den = vrw_pkg::DEN_W'(r_len);
            end
            ST_DIV_TM: begin
                div_num = vrw_pkg::NUM_W'({span, 30'b0});
                div_den = vrw_pkg::DEN_W'(r_a);
            end
            ST_DIV_TD: begin
                div_num = vrw_pkg::NUM_W'({r_c[r_ax], 30'b0});
                div_den = vrw_pkg::DEN_W'(r_a);
            end
            default: begin
                div_num = vrw_pkg::NUM_W'(abs_p);
                div_den = vrw_pkg::DEN_W'(r_c[r_ax]);
            end
        endcase
        // A zero-length ray needs no direction division at all.
        div_start = !r_wait && (r_state == ST_DIV_S || r_state == ST_DIV_E
                 || (r_state == ST_DIV_A && r_len != '0) || r_state == ST_DIV_TM
                 || r_state == ST_DIV_TD);
    end

    // Per-axis difference magnitudes at acceptance.
    always_comb begin
        diff[0]  = 33'(i_ray.end_x) - 33'(i_ray.start_x);
        diff[1]  = 33'(i_ray.end_y) - 33'(i_ray.start_y);
        diff[2]  = 33'(i_ray.end_z) - 33'(i_ray.start_z);
        for (int k = 0; k < 3; k++) begin
            adiff[k] = diff[k][32] ? 33'(-diff[k]) : 33'(diff[k]);
        end
    end

    assign sq_try = r_res + r_bit;

    vrw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // Set-up sequencer and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
            r_ax    <= '0;
            r_cell[0] <= 31'd65536;
            r_cell[1] <= 31'd65536;
            r_cell[2] <= 31'd65536;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    vrw_pkg::REG_CELL_X: r_cell[0] <= i_cfg_data;
                    vrw_pkg::REG_CELL_Y: r_cell[1] <= i_cfg_data;
                    vrw_pkg::REG_CELL_Z: r_cell[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (div_start) begin
                r_wait <= 1'b1;
            end
            if (div_done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_push) begin
                        r_s[0] <= i_ray.start_x; r_s[1] <= i_ray.start_y;
                        r_s[2] <= i_ray.start_z;
                        r_e[0] <= i_ray.end_x;   r_e[1] <= i_ray.end_y;
                        r_e[2] <= i_ray.end_z;
                        for (int k = 0; k < 3; k++) begin
                            r_c[k]   <= (r_cell[k] == '0) ? 31'd1 : r_cell[k];
                            r_mag[k] <= adiff[k];
                        end
                        r_sum   <= '0;
                        r_res   <= '0;
                        r_bit   <= 64'(1) << 62;
                        r_ax    <= '0;
                        r_state <= ST_DIV_S;
                    end
                end
                ST_DIV_S: begin
                    if (div_done) begin
                        r_setup.cur[r_ax] <= fl_q;
                        r_r[r_ax] <= !sel_p[31] ? rem31
                                   : (rem31 == '0) ? 31'd0 : 31'(r_c[r_ax] - rem31);
                        r_state <= ST_DIV_E;
                    end
                end
                ST_DIV_E: begin
                    if (div_done) begin
                        r_setup.last[r_ax] <= fl_q;
                        if (r_ax == 2'd2) begin
                            r_ax    <= '0;
                            r_state <= ST_HALVE;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= ST_DIV_S;
                        end
                    end
                end
                ST_HALVE: begin
                    // Halve every component when any reaches 2^31.
                    if ((|r_mag[0][32:31]) || (|r_mag[1][32:31]) || (|r_mag[2][32:31])) begin
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= r_mag[k] >> 1;
                        end
                    end
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    // One square per cycle; each product is registered and then added to the sum.
                    r_prod <= (r_ax == 2'd3) ? 62'd0
                            : 62'(r_mag[r_ax][30:0]) * 62'(r_mag[r_ax][30:0]);
                    r_sum  <= (r_ax == 2'd0) ? r_sum : r_sum + 64'(r_prod);
                    if (r_ax == 2'd3) begin
                        r_ax    <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                    end
                end
                ST_SQRT: begin
                    // One result bit per cycle.
                    if (r_sum >= sq_try) begin
                        r_sum <= r_sum - sq_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_len   <= (r_sum >= sq_try) ? 32'((r_res >> 1) + r_bit)
                                                     : 32'(r_res >> 1);
                        r_state <= ST_DIV_A;
                    end
                end
                ST_DIV_A: begin
                    if (r_len == '0 && !r_wait) begin
                        r_setup.neg[r_ax]  <= 1'b0;
                        r_setup.tmax[r_ax] <= vrw_pkg::T_INF;
                        r_setup.tdel[r_ax] <= vrw_pkg::T_INF;
                        r_state <= (r_ax == 2'd2) ? ST_PUSH : ST_DIV_A;
                        r_ax    <= (r_ax == 2'd2) ? 2'd0 : r_ax + 1'b1;
                    end else if (div_done) begin
                        r_a <= a_next;
                        if (a_next == '0) begin
                            r_setup.neg[r_ax]  <= 1'b0;
                            r_setup.tmax[r_ax] <= vrw_pkg::T_INF;
                            r_setup.tdel[r_ax] <= vrw_pkg::T_INF;
                            r_state <= (r_ax == 2'd2) ? ST_PUSH : ST_DIV_A;
                            r_ax    <= (r_ax == 2'd2) ? 2'd0 : r_ax + 1'b1;
                        end else begin
                            r_setup.neg[r_ax] <= (sel_e < sel_s);
                            r_state <= ST_DIV_TM;
                        end
                    end
                end
                ST_DIV_TM: begin
                    if (div_done) begin
                        r_setup.tmax[r_ax] <= vrw_pkg::TIME_W'(div_quo);
                        r_state <= ST_DIV_TD;
                    end
                end
                ST_DIV_TD: begin
                    if (div_done) begin
                        r_setup.tdel[r_ax] <= vrw_pkg::TIME_W'(div_quo);
                        r_state <= (r_ax == 2'd2) ? ST_PUSH : ST_DIV_A;
                        r_ax    <= (r_ax == 2'd2) ? 2'd0 : r_ax + 1'b1;
                    end
                end
                ST_PUSH: begin
                    if (!i_setup_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The zero-length guard above must not fire while a division is in flight.
    assign o_full       = (r_state != ST_IDLE);
    assign o_setup_push = (r_state == ST_PUSH) && !i_setup_full;
    assign o_setup      = r_setup;

endmodule

// ===== rtl/core/vrw_setupq.sv =====
// Two-entry queue of walk set-ups between the front end and the stepping engine.
// Depends on vrw_pkg for the set-up record type.
`timescale 1ns / 1ps

module vrw_setupq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vrw_pkg::t_setup i_data,
    output logic            o_full,
    input  logic            i_pop,
    output vrw_pkg::t_setup o_data,
    output logic            o_empty
);

    vrw_pkg::t_setup r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

endmodule

// ===== rtl/core/vrw_back.sv =====
// Stepping engine: walks the voxel grid one voxel per cycle while the result queue has room, and queues the results.
// Depends on vrw_pkg for the set-up and result types.
`timescale 1ns / 1ps

module vrw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_setup_empty,
    input  vrw_pkg::t_setup i_setup,
    output logic            o_setup_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output vrw_pkg::t_res   o_res
);

    typedef enum logic {ST_IDLE, ST_WALK} t_state;

    t_state r_state;
    vrw_pkg::t_coord r_cur  [3];
    vrw_pkg::t_coord r_last [3];
    logic  [2:0]     r_neg;
    vrw_pkg::t_time  r_tmax [3];
    vrw_pkg::t_time  r_tdel [3];
    vrw_pkg::t_time  r_pre_t;
    logic            r_first;
    logic [5:0]      r_steps;

    vrw_pkg::t_res r_q [4];
    logic [1:0]    r_wr;
    logic [1:0]    r_rd;
    logic [2:0]    r_cnt;

    logic           lt01, lt02, lt12;
    logic [1:0]     sel;
    vrw_pkg::t_time t_min;
    vrw_pkg::t_time seg;
    logic           done, trunc, fire, q_pop;
    vrw_pkg::t_res  res;
    logic [63:0]    sum [3];

    // Stepping axis; ties go to y or z. The smallest tMax is that axis's.
    always_comb begin
        lt01 = r_tmax[0] < r_tmax[1];
        lt02 = r_tmax[0] < r_tmax[2];
        lt12 = r_tmax[1] < r_tmax[2];
        if (lt01) begin
            sel = lt02 ? 2'd0 : 2'd2;
        end else begin
            sel = lt12 ? 2'd1 : 2'd2;
        end
        unique case (sel)
            2'd0:    t_min = r_tmax[0];
            2'd1:    t_min = r_tmax[1];
            default: t_min = r_tmax[2];
        endcase
        seg   = r_first ? t_min : t_min - r_pre_t;
        done  = (r_cur[0] == r_last[0]) && (r_cur[1] == r_last[1])
             && (r_cur[2] == r_last[2]);
        trunc = !done && (r_steps >= 6'(vrw_pkg::MAX_STEPS));
        for (int k = 0; k < 3; k++) begin
            sum[k] = 64'(r_tmax[k]) + 64'(r_tdel[k]);
        end
        res.voxel_x        = r_cur[0][15:0];
        res.voxel_y        = r_cur[1][15:0];
        res.voxel_z        = r_cur[2][15:0];
        res.segment_length = (|seg[vrw_pkg::TIME_W-1:32]) ? 32'hFFFF_FFFF : seg[31:0];
        res.is_last        = done || trunc;
        res.truncated      = trunc;
    end

    assign fire        = (r_state == ST_WALK) && (r_cnt != 3'd4);
    assign o_setup_pop = (r_state == ST_IDLE) && !i_setup_empty;
    assign q_pop       = i_pop && !o_empty;

    // Walk sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_setup_empty) begin
                        for (int k = 0; k < 3; k++) begin
                            r_cur[k]  <= i_setup.cur[k];
                            r_last[k] <= i_setup.last[k];
                            r_tmax[k] <= i_setup.tmax[k];
                            r_tdel[k] <= i_setup.tdel[k];
                        end
                        r_neg   <= i_setup.neg;
                        r_first <= 1'b1;
                        r_steps <= '0;
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (fire) begin
                        r_pre_t <= t_min;
                        r_first <= 1'b0;
                        if (done || trunc) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_steps <= r_steps + 1'b1;
                            for (int k = 0; k < 3; k++) begin
                                if (sel == 2'(k)) begin
                                    r_cur[k]  <= r_neg[k] ? r_cur[k] - 1'b1
                                                          : r_cur[k] + 1'b1;
                                    r_tmax[k] <= (sum[k] > 64'(vrw_pkg::T_INF))
                                               ? vrw_pkg::T_INF
                                               : sum[k][vrw_pkg::TIME_W-1:0];
                                end
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_q[r_wr] <= res;
        end
    end

    // Result queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (fire) begin
                r_wr <= r_wr + 1'b1;
            end
            if (q_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + 3'(fire) - 3'(q_pop);
        end
    end

    assign o_empty = (r_cnt == 3'd0);
    assign o_res   = r_q[r_rd];

endmodule

// ===== rtl/core/voxel_ray_walker_3d.sv =====
// Top level of the 3D voxel ray walker: front end, set-up queue and stepping engine.
// Depends on vrw_pkg, vrw_front, vrw_setupq and vrw_back.
`timescale 1ns / 1ps

// Each ray's set-up in the front end runs fifteen divisions on one shared radix-2
// divider with 62 quotient bits (six floor divisions, then per axis the direction,
// first crossing and crossing spacing), a square root and the sequencing between
// them; fewer divisions when an axis has no direction. The stepping engine then emits
// one voxel per cycle while its result queue has room, up to 64 results per ray, and
// works on the previous ray while the front end sets up the next one. A ray is taken
// only while the front end is idle (full low). Cell size writes are always accepted.

module voxel_ray_walker_3d (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  vrw_pkg::t_ray       i_ray,
    output logic                empty,
    input  logic                pop,
    output vrw_pkg::t_res       o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [30:0]         i_cfg_data
);

    logic            setup_push, setup_full, setup_pop, setup_empty;
    vrw_pkg::t_setup setup_in, setup_out;
    logic            push_ok;

    assign o_cfg_ready = 1'b1;
    assign push_ok     = push && !full;

    vrw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_ok),
        .o_full       (full),
        .i_ray        (i_ray),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_setup_push (setup_push),
        .i_setup_full (setup_full),
        .o_setup      (setup_in)
    );

    vrw_setupq u_setupq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (setup_push),
        .i_data  (setup_in),
        .o_full  (setup_full),
        .i_pop   (setup_pop),
        .o_data  (setup_out),
        .o_empty (setup_empty)
    );

    vrw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_setup_empty (setup_empty),
        .i_setup       (setup_out),
        .o_setup_pop   (setup_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_res         (o_res)
    );

endmodule

// ===== rtl/core/vrw_checker.sv =====
// Port-level checks for the voxel ray walker, bound to the top level.
// Depends on vrw_pkg and voxel_ray_walker_3d.
`timescale 1ns / 1ps

module vrw_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          push,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input vrw_pkg::t_res o_res
);

    // Reset leaves no results waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results visible after reset");

    // An accepted ray keeps the front end busy for its set-up.
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("front end idle right after a ray request");

    // Truncation is flagged only on the final voxel of a ray.
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_res.truncated |-> o_res.is_last)
        else $error("truncated result not marked last");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_res))
        else $error("waiting result changed");

endmodule

bind voxel_ray_walker_3d vrw_checker u_vrw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);

// ===== sim/tb_voxel_ray_walker_3d.sv =====
// Self-checking testbench for voxel_ray_walker_3d: rays go in through the push/full handshake,
// visited voxels are checked against a DDA predictor inside a small scoreboard class.
// Depends on vrw_pkg and the voxel_ray_walker_3d RTL.
`timescale 1ns / 1ps

module tb_voxel_ray_walker_3d;
    import vrw_pkg::*;

    localparam longint unsigned TINF     = 64'd1 << 62;
    localparam int              LIMIT    = 6000000;
    localparam int              LONG_OFF = 9000;

    // Walk predictor and store of expected voxels.
    class voxel_board;
        longint csize[3];
        t_res   voxels_due[$];
        int     errors;
        int     shown;

        function new();
            csize[0] = 65536;
            csize[1] = 65536;
            csize[2] = 65536;
            errors   = 0;
            shown    = 0;
        endfunction

        function void set_cell(int idx, logic [30:0] val);
            csize[idx] = (val == 0) ? 1 : longint'(val);
        endfunction

        function int pending();
            return voxels_due.size();
        endfunction

        function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            return q;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res, bt;
            res = 0;
            bt  = 64'd1 << 62;
            while (bt > v) bt >>= 2;
            while (bt != 0) begin
                if (v >= res + bt) begin
                    v   -= res + bt;
                    res  = (res >> 1) + bt;
                end else begin
                    res >>= 1;
                end
                bt >>= 2;
            end
            return res;
        endfunction

        // Works out every voxel of an accepted ray and queues it.
        function void note_ray(t_ray r);
            longint          s[3], e[3], cur[3], lst[3], stp[3], d, rr;
            longint unsigned mag[3], tmx[3], tdl[3], a, span, sum, ln, mx, t, pre, seg;
            int              i, ax, n, steps;
            bit              done, trunc;
            t_res            res;
            s[0] = longint'(r.start_x); s[1] = longint'(r.start_y);
            s[2] = longint'(r.start_z);
            e[0] = longint'(r.end_x);   e[1] = longint'(r.end_y);
            e[2] = longint'(r.end_z);
            mx = 0;
            for (i = 0; i < 3; i++) begin
                cur[i] = fdiv(s[i], csize[i]);
                lst[i] = fdiv(e[i], csize[i]);
                d      = e[i] - s[i];
                mag[i] = (d < 0) ? longint'(-d) : d;
                if (mag[i] > mx) mx = mag[i];
            end
            if (mx >= (64'd1 << 31))
                for (i = 0; i < 3; i++) mag[i] >>= 1;
            sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            ln  = root(sum);
            for (i = 0; i < 3; i++) begin
                a = 0;
                if (ln != 0) begin
                    a = ((mag[i] << DIR_BITS) + (ln >> 1)) / ln;
                    if (a > (64'd1 << DIR_BITS)) a = 64'd1 << DIR_BITS;
                end
                stp[i] = (a != 0 && e[i] < s[i]) ? -1 : 1;
                rr     = s[i] - cur[i] * csize[i];
                if (a == 0) begin
                    tmx[i] = TINF;
                    tdl[i] = TINF;
                end else begin
                    span   = (stp[i] > 0) ? longint'(csize[i] - rr) : longint'(rr);
                    tmx[i] = (span << DIR_BITS) / a;
                    tdl[i] = (longint'(csize[i]) << DIR_BITS) / a;
                end
            end
            t     = (tmx[0] < tmx[1]) ? tmx[0] : tmx[1];
            t     = (t < tmx[2]) ? t : tmx[2];
            pre   = t;
            n     = 0;
            steps = 0;
            forever begin
                done  = (cur[0] == lst[0]) && (cur[1] == lst[1]) && (cur[2] == lst[2]);
                trunc = !done && steps >= MAX_STEPS;
                seg   = (n == 0) ? t : t - pre;
                if (n != 0) pre = t;
                res.voxel_x        = cur[0][15:0];
                res.voxel_y        = cur[1][15:0];
                res.voxel_z        = cur[2][15:0];
                res.segment_length = (seg > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : seg[31:0];
                res.is_last        = done || trunc;
                res.truncated      = trunc;
                voxels_due.insert(voxels_due.size(), res);
                n++;
                if (done || trunc) break;
                if (tmx[0] < tmx[1]) ax = (tmx[0] < tmx[2]) ? 0 : 2;
                else                 ax = (tmx[1] < tmx[2]) ? 1 : 2;
                cur[ax] += stp[ax];
                tmx[ax]  = tmx[ax] + tdl[ax];
                if (tmx[ax] > TINF) tmx[ax] = TINF;
                t = (tmx[0] < tmx[1]) ? tmx[0] : tmx[1];
                t = (t < tmx[2]) ? t : tmx[2];
                steps++;
            end
        endfunction

        // Compares one popped voxel with the oldest expected one.
        function void check(t_res got);
            t_res want;
            bit   bad;
            if (voxels_due.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected voxel %0d %0d %0d len %h", got.voxel_x,
                             got.voxel_y, got.voxel_z, got.segment_length);
                end
                return;
            end
            want = voxels_due.pop_front();
            bad  = (got.voxel_x != want.voxel_x) || (got.voxel_y != want.voxel_y) ||
                   (got.voxel_z != want.voxel_z) ||
                   (got.segment_length != want.segment_length) ||
                   (got.is_last != want.is_last) || (got.truncated != want.truncated);
            if (bad) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("mismatch exp %0d %0d %0d len %h last %b trunc %b",
                             want.voxel_x, want.voxel_y, want.voxel_z,
                             want.segment_length, want.is_last, want.truncated);
                    $display("         got %0d %0d %0d len %h last %b trunc %b",
                             got.voxel_x, got.voxel_y, got.voxel_z,
                             got.segment_length, got.is_last, got.truncated);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_ray        i_ray = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_res        o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_CELL_X;
    logic [30:0] i_cfg_data = '0;

    voxel_board  board = new();
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          pop_pct = 100;
    int          cycles = 0;

    voxel_ray_walker_3d u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_ray       (i_ray),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL voxel_ray_walker_3d");
            $finish;
        end
    end

    // Receiver: checks popped voxels and stalls on its own pattern.
    always @(posedge i_clk) begin
        if (pop && !empty) board.check(o_res);
        if (cycles % 300 == 0) pop_pct <= (cycles % 900 == 0) ? 100 : $urandom_range(20, 90);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= LONG_OFF;
            pop       <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) < pop_pct);
        end
    end

    // Offers one ray request and waits until it is taken.
    task automatic send_ray(t_ray r);
        i_ray <= r;
        push  <= 1'b1;
        do @(posedge i_clk); while (full);
        board.note_ray(r);
    endtask

    task automatic rest(int n);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    // One register write, with valid dropped again before the next one.
    task automatic write_cell(logic [1:0] idx, logic [30:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_cell(idx, val);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Random ray: mostly short walks over a few cells, some fully random or axis aligned.
    function automatic t_ray rand_ray();
        t_ray   r;
        longint st[3], en[3], c;
        int     i, kind;
        kind = $urandom_range(0, 9);
        for (i = 0; i < 3; i++) begin
            c     = board.csize[i];
            st[i] = longint'($urandom_range(0, 20)) * c - 10 * c + $urandom_range(0, 65535);
            en[i] = st[i] + (longint'($urandom_range(0, 16)) - 8) * c
                    + longint'($urandom_range(0, 131071)) - 65536;
            if (kind == 0) begin
                st[i] = longint'(signed'($urandom()));
                en[i] = longint'(signed'($urandom()));
            end
            if (kind == 1 && i != 0) en[i] = st[i];
        end
        r.start_x = clamp32(st[0]); r.start_y = clamp32(st[1]); r.start_z = clamp32(st[2]);
        r.end_x   = clamp32(en[0]); r.end_y   = clamp32(en[1]); r.end_z   = clamp32(en[2]);
        return r;
    endfunction

    task automatic random_rays(int cnt);
        int k, burst;
        k = 0;
        while (k < cnt) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                if (k < cnt) begin
                    send_ray(rand_ray());
                    k++;
                end
            end
            if ($urandom_range(0, 3) != 0) rest($urandom_range(1, 1500));
        end
    endtask

    function automatic t_ray mk(longint sx, longint sy, longint sz,
                                longint ex, longint ey, longint ez);
        t_ray r;
        r.start_x = sx[31:0]; r.start_y = sy[31:0]; r.start_z = sz[31:0];
        r.end_x   = ex[31:0]; r.end_y   = ey[31:0]; r.end_z   = ez[31:0];
        return r;
    endfunction

    // Stimulus: directed rays, then random phases over several cell sizes.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Start equals end, positive and negative.
        send_ray(mk(32'h18000, 32'h28000, 32'h38000, 32'h18000, 32'h28000, 32'h38000));
        send_ray(mk(-98304, -1, -65536, -98304, -1, -65536));
        // Axis aligned, both directions, and an exact diagonal tie.
        send_ray(mk(32'h8000, 32'h8000, 32'h8000, 32'h48000, 32'h8000, 32'h8000));
        send_ray(mk(32'h8000, 32'h48000, 32'h8000, 32'h8000, -32768, 32'h8000));
        send_ray(mk(0, 0, 32'h28000, 0, 0, -163840));
        send_ray(mk(0, 0, 0, 32'h30000, 32'h30000, 32'h30000));
        send_ray(mk(32'h10000, 32'h10000, 0, 0, 0, 0));
        // Tiny component along x against a huge move along y.
        send_ray(mk(32'hFFFF, -2147483648, 0, 32'h10000, 2147483647, 0));
        // Extreme coordinates: wide indexes and a step limit.
        send_ray(mk(-2147483648, -2147483648, -2147483648,
                    2147483647, 2147483647, 2147483647));
        send_ray(mk(2147483647, -2147483648, 0, -2147483648, 2147483647, 0));
        send_ray(mk(2147483647, 2147483647, 2147483647, 2147483647, 2147483647, 2147483647));
        send_ray(mk(0, 0, 0, 32'h7FFF, 32'h7FFF, 32'h7FFF));
        drain();

        // Long receiver hold while the sender keeps going.
        hold_req <= hold_req + 1;
        random_rays(20);
        drain();
        random_rays(60);
        drain();

        // Cell size of one: nearly every ray hits the step limit.
        write_cell(REG_CELL_X, 31'd1);
        write_cell(REG_CELL_Y, 31'd1);
        write_cell(REG_CELL_Z, 31'd1);
        send_ray(mk(0, 0, 0, 5, -3, 2));
        random_rays(60);
        drain();

        // Largest cell size and zero, which acts as one.
        write_cell(REG_CELL_X, 31'h7FFF_FFFF);
        write_cell(REG_CELL_Y, 31'd0);
        write_cell(REG_CELL_Z, 31'h7FFF_FFFF);
        send_ray(mk(-2147483648, 0, -1, 2147483647, 3, 0));
        random_rays(60);
        drain();

        // Mixed random sizes.
        repeat (3) begin
            write_cell(REG_CELL_X, 31'($urandom_range(4096, 400000)));
            write_cell(REG_CELL_Y, 31'($urandom_range(4096, 400000)));
            write_cell(REG_CELL_Z, 31'($urandom_range(4096, 400000)));
            random_rays(70);
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS voxel_ray_walker_3d");
        end else begin
            $display("FAIL voxel_ray_walker_3d");
        end
        $finish;
    end

endmodule
